### rtl/i2cvm_pkg.sv
// ----------------------------------------------------------------------------
// i2cvm_pkg: shared definitions for the I2C slave virtual memory
// Default sizes, bus event codes and the out-of-range read byte.
// ----------------------------------------------------------------------------
package i2cvm_pkg;

  localparam int MEM_DEPTH_DEF  = 256;
  localparam int ADDR_BYTES_DEF = 3;

  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 32;
  localparam int LEFT_W   = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RX   = 2'd0,
    ACT_RD   = 2'd1,
    ACT_STOP = 2'd2
  } action_t;

  localparam logic [BYTE_W-1:0] OOR_BYTE = 8'hFF;

  localparam logic [CFG_AW-1:0] REG_BASE_ADDRESS = 3'd0;

endpackage

### rtl/i2c_slave_virtual_memory_core.sv
// Throughput: one request per cycle while in_stall is low; only read
// requests give a result. A read's byte goes from the memory read port
// into rd_data_r, then into out_tx_byte_r; out_stall can hold it on the way.
// Reset: synchronous, active low; then a clearing pass writes zero to each
// of the MEM_DEPTH entries; in_stall stays high (configuration still taken).
// ----------------------------------------------------------------------------
// i2c_slave_virtual_memory_core: EEPROM-style byte memory behind an I2C slave
// Builds the target address from the first bytes after a stop, then writes
// received bytes and answers read requests at an incrementing address.
// ----------------------------------------------------------------------------
module i2c_slave_virtual_memory_core #(
  parameter int MEM_DEPTH  = i2cvm_pkg::MEM_DEPTH_DEF,
  parameter int ADDR_BYTES = i2cvm_pkg::ADDR_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [i2cvm_pkg::ACTION_W-1:0]   in_action,
  input  logic [i2cvm_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [i2cvm_pkg::BYTE_W-1:0]     out_tx_byte,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [i2cvm_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [i2cvm_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [i2cvm_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                             cfg_pready
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int AWD = i2cvm_pkg::ADDR_W;
  localparam int LW = i2cvm_pkg::LEFT_W;
  localparam int BW = i2cvm_pkg::BYTE_W;
  localparam logic [AWD-1:0] DEPTH_W = AWD'(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);
  localparam logic [LW-1:0] ADDR_BYTES_W = LW'(ADDR_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [LW-1:0]    left_r, left_nxt;
  logic [AWD-1:0]   addr_r, addr_nxt;
  logic [AWD-1:0]   base_r;
  logic             clearing_r;
  logic [AW-1:0]    clr_cnt_r;
  logic [BW-1:0]    mem [MEM_DEPTH];
  logic [BW-1:0]    rd_data_r;
  logic             s1_valid_r, s1_in_range_r;
  logic             out_valid_r;
  logic [BW-1:0]    out_tx_byte_r;

  logic             in_acc, s1_move, cfg_wr;
  logic [AWD-1:0]   offset;
  logic             in_range;
  logic             wr_en, rd_req;
  logic [LW-1:0]    left_cur, left_dec;
  logic [AWD-1:0]   addr_cur, rx_shifted;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [BW-1:0]    mem_wdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr == i2cvm_pkg::REG_BASE_ADDRESS) ? base_r : '0;

  assign s1_move  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = clearing_r | (s1_valid_r & out_valid_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  assign offset   = addr_r - base_r;
  assign in_range = offset < DEPTH_W;

  assign left_cur   = (phase_r == PH_ADDR) ? left_r : ADDR_BYTES_W;
  assign addr_cur   = (phase_r == PH_ADDR) ? addr_r : '0;
  assign left_dec   = (left_cur != '0) ? left_cur - LW'(1) : left_cur;
  assign rx_shifted = AWD'(in_rx_byte) << {left_dec[1:0], 3'b000};

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    addr_nxt  = addr_r;
    wr_en     = 1'b0;
    rd_req    = 1'b0;
    if (in_acc) begin
      case (in_action)
        i2cvm_pkg::ACT_RX: begin
          if (phase_r == PH_DATA) begin
            wr_en    = in_range;
            addr_nxt = addr_r + AWD'(1);
          end else begin
            addr_nxt  = addr_cur + rx_shifted;
            left_nxt  = left_dec;
            phase_nxt = (left_dec == '0) ? PH_DATA : PH_ADDR;
          end
        end
        i2cvm_pkg::ACT_RD: begin
          rd_req    = 1'b1;
          phase_nxt = PH_DATA;
          addr_nxt  = addr_r + AWD'(1);
        end
        i2cvm_pkg::ACT_STOP: begin
          phase_nxt = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  assign mem_we    = clearing_r | wr_en;
  assign mem_waddr = clearing_r ? clr_cnt_r : offset[AW-1:0];
  assign mem_wdata = clearing_r ? '0 : in_rx_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_req) begin
      rd_data_r     <= mem[offset[AW-1:0]];
      s1_in_range_r <= in_range;
    end
    if (s1_move) begin
      out_tx_byte_r <= s1_in_range_r ? rd_data_r : i2cvm_pkg::OOR_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      left_r      <= '0;
      addr_r      <= '0;
      base_r      <= '0;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      addr_r  <= addr_nxt;
      if (cfg_wr && cfg_paddr == i2cvm_pkg::REG_BASE_ADDRESS) begin
        base_r <= cfg_pwdata;
      end
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_IDX) begin
          clearing_r <= 1'b0;
        end
      end
      if (rd_req) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_tx_byte_r;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> in_stall)
    else $error("request accepted during clearing pass");

  a_pending_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("request accepted with read stage blocked");

  a_addr_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ADDR) |-> (left_r != '0 && left_r < ADDR_BYTES_W))
    else $error("address byte count out of range");

  a_read_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_req && !out_valid_r) |=> s1_valid_r ##1 out_valid_r)
    else $error("read request lost on the way to the output");
`endif

endmodule
